/* rtl/daqhi_pkg.sv */
// widths, coefficients and shared helpers of the daily aqhi engine
package daqhi_pkg;

	localparam int SAMPLE_W = 20;
	localparam int AVG_W = 19;
	localparam int SUM_W = 24;
	localparam int CNT_W = 5;
	localparam int HOUR_W = 5;
	localparam int MONTH_W = 4;
	localparam int IDX_W = 8;
	localparam int RISK_W = 2;
	localparam int NPOL = 3;
	localparam int HOURS_PER_DAY = 24;

	localparam logic [SAMPLE_W-1:0] MISSING_MARK = 20'd99990;

	// fixed point datapath widths
	localparam int FRAC_W = 24;
	localparam int K_W = 27;
	localparam int ARGP_W = AVG_W + K_W;
	localparam int ARG_SH = 16;
	localparam int X_W = 26;
	localparam int TERM_W = 26;
	localparam int TP_W = TERM_W + X_W;
	localparam int Y_W = TP_W - FRAC_W;
	localparam int RCP_W = 32;
	localparam int QP_W = Y_W + RCP_W;
	localparam int REM_W = 6;
	localparam int ESUM_W = 28;
	localparam int S_W = 30;
	localparam int F_W = 24;
	localparam int P_W = S_W + F_W;
	localparam int RND_POS = 40;
	localparam int N_TERMS = 20;

	localparam logic [ARGP_W-ARG_SH-1:0] ARG_CAP = (ARGP_W-ARG_SH)'(2) << FRAC_W;
	localparam logic [ESUM_W-1:0] ONE_Q24 = ESUM_W'(1) << FRAC_W;

	// exponent coefficients, k / 10 scaled by 2^40
	localparam logic [K_W-1:0] K_STD_O3 =
		K_W'((64'd537 * 64'd1099511627776 + 64'd5000000) / 64'd10000000);
	localparam logic [K_W-1:0] K_STD_NO2 =
		K_W'((64'd871 * 64'd1099511627776 + 64'd5000000) / 64'd10000000);
	localparam logic [K_W-1:0] K_STD_PM =
		K_W'((64'd487 * 64'd1099511627776 + 64'd5000000) / 64'd10000000);
	localparam logic [K_W-1:0] K_COOL_NO2 =
		K_W'((64'd457 * 64'd1099511627776 + 64'd5000000) / 64'd10000000);
	localparam logic [K_W-1:0] K_COOL_PM =
		K_W'((64'd462 * 64'd1099511627776 + 64'd5000000) / 64'd10000000);
	localparam logic [K_W-1:0] K_WARM_O3 =
		K_W'((64'd1040 * 64'd1099511627776 + 64'd5000000) / 64'd10000000);
	localparam logic [K_W-1:0] K_WARM_NO2 =
		K_W'((64'd1010 * 64'd1099511627776 + 64'd5000000) / 64'd10000000);
	localparam logic [K_W-1:0] K_WARM_PM =
		K_W'((64'd621 * 64'd1099511627776 + 64'd5000000) / 64'd10000000);

	// 1000 / divisor scaled by 2^16
	localparam logic [F_W-1:0] F_STD = F_W'((64'd655360000 + 64'd52) / 64'd104);
	localparam logic [F_W-1:0] F_COOL = F_W'((64'd6553600000 + 64'd321) / 64'd643);
	localparam logic [F_W-1:0] F_WARM = F_W'(64'd5120000);

	localparam logic [RISK_W-1:0] RISK_LOW = 2'd0;
	localparam logic [RISK_W-1:0] RISK_MODERATE = 2'd1;
	localparam logic [RISK_W-1:0] RISK_HIGH = 2'd2;
	localparam logic [RISK_W-1:0] RISK_VERY_HIGH = 2'd3;
	localparam logic [IDX_W-1:0] LIM_MODERATE = 8'd4;
	localparam logic [IDX_W-1:0] LIM_HIGH = 8'd7;
	localparam logic [IDX_W-1:0] LIM_VERY_HIGH = 8'd11;

	// floor((2^32 - 1) / n); a product with this is low by at most one
	function automatic logic [RCP_W-1:0] recip(input logic [4:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			5'd1: r = 32'hFFFF_FFFF;
			5'd2: r = 32'hFFFF_FFFF / 32'd2;
			5'd3: r = 32'hFFFF_FFFF / 32'd3;
			5'd4: r = 32'hFFFF_FFFF / 32'd4;
			5'd5: r = 32'hFFFF_FFFF / 32'd5;
			5'd6: r = 32'hFFFF_FFFF / 32'd6;
			5'd7: r = 32'hFFFF_FFFF / 32'd7;
			5'd8: r = 32'hFFFF_FFFF / 32'd8;
			5'd9: r = 32'hFFFF_FFFF / 32'd9;
			5'd10: r = 32'hFFFF_FFFF / 32'd10;
			5'd11: r = 32'hFFFF_FFFF / 32'd11;
			5'd12: r = 32'hFFFF_FFFF / 32'd12;
			5'd13: r = 32'hFFFF_FFFF / 32'd13;
			5'd14: r = 32'hFFFF_FFFF / 32'd14;
			5'd15: r = 32'hFFFF_FFFF / 32'd15;
			5'd16: r = 32'hFFFF_FFFF / 32'd16;
			5'd17: r = 32'hFFFF_FFFF / 32'd17;
			5'd18: r = 32'hFFFF_FFFF / 32'd18;
			5'd19: r = 32'hFFFF_FFFF / 32'd19;
			5'd20: r = 32'hFFFF_FFFF / 32'd20;
			default: r = 32'hFFFF_FFFF;
		endcase
		return r;
	endfunction

endpackage

/* rtl/daqhi_if.sv */
// handshake channels of the daily aqhi engine
interface daqhi_sample_if;
	import daqhi_pkg::*;
	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] o3_sample;
	logic signed [SAMPLE_W-1:0] no2_sample;
	logic signed [SAMPLE_W-1:0] pm25_sample;
	modport source (output valid, o3_sample, no2_sample, pm25_sample, input ready);
	modport sink (input valid, o3_sample, no2_sample, pm25_sample, output ready);
endinterface

interface daqhi_result_if;
	import daqhi_pkg::*;
	logic valid;
	logic ready;
	logic [AVG_W-1:0] o3_average;
	logic [AVG_W-1:0] no2_average;
	logic [AVG_W-1:0] pm25_average;
	logic [IDX_W-1:0] standard_index;
	logic [IDX_W-1:0] seasonal_index;
	logic seasonal_valid;
	logic [RISK_W-1:0] standard_risk;
	logic [RISK_W-1:0] seasonal_risk;
	modport source (output valid, o3_average, no2_average, pm25_average, standard_index,
		seasonal_index, seasonal_valid, standard_risk, seasonal_risk, input ready);
	modport sink (input valid, o3_average, no2_average, pm25_average, standard_index,
		seasonal_index, seasonal_valid, standard_risk, seasonal_risk, output ready);
endinterface

interface daqhi_cfg_if;
	import daqhi_pkg::*;
	logic valid;
	logic ready;
	logic [MONTH_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/daqhi_div.sv */
// restoring divider, one quotient bit per cycle, for the daily averages
module daqhi_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [daqhi_pkg::SUM_W-1:0] dividend,
	input  logic [daqhi_pkg::CNT_W-1:0] divisor,
	output logic busy,
	output logic [daqhi_pkg::SUM_W-1:0] quotient
);
	import daqhi_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0] den_q;
	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits = trial >= {1'b0, den_q};
	assign busy = step_q != '0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(SUM_W);
		end else if (busy) begin
			step_q <= step_q - 1'b1;
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

endmodule

/* rtl/daily_aqhi_engine_top.sv */
// daily aqhi engine: hourly accumulation and a microcoded end-of-day index engine
// sequence: a word that does not close the day is taken with no result; the closing word
//   yields its result after three divisions, six exponentials on the shared series multiplier,
//   the index multiply and store steps of each group and the emit step
// throughput: one word per cycle within a day; no word is taken while the day closes
// reset: sums, counts and hour cleared, month set to 1, sequencer idle, no result held
module daily_aqhi_engine_top (
	input logic clk,
	input logic arst_n,
	daqhi_sample_if.sink sample,
	daqhi_result_if.source result,
	daqhi_cfg_if.sink cfg
);
	import daqhi_pkg::*;

	localparam int PC_W = 4;
	localparam int E_W = 3;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_DIV_GO,
		OP_DIV_STORE,
		OP_EXP_INIT,
		OP_ARG_CLAMP,
		OP_TERM_MUL,
		OP_RECIP_MUL,
		OP_TERM_DIVQ,
		OP_TERM_FIX,
		OP_EXP_ACC,
		OP_IDX_MUL,
		OP_IDX_STORE,
		OP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_DAY,
		C_DIV_BUSY,
		C_POL_MORE,
		C_TERM_MORE,
		C_GROUP_MORE,
		C_SEA_LEFT
	} ucond_t;

	typedef struct packed {
		uop_t op;
		ucond_t cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	localparam logic [PC_W-1:0] A_IDLE = 4'd0;
	localparam logic [PC_W-1:0] A_DIV_GO = 4'd1;
	localparam logic [PC_W-1:0] A_DIV_WAIT = 4'd2;
	localparam logic [PC_W-1:0] A_DIV_STORE = 4'd3;
	localparam logic [PC_W-1:0] A_EXP_INIT = 4'd4;
	localparam logic [PC_W-1:0] A_ARG_CLAMP = 4'd5;
	localparam logic [PC_W-1:0] A_TERM_MUL = 4'd6;
	localparam logic [PC_W-1:0] A_RECIP_MUL = 4'd7;
	localparam logic [PC_W-1:0] A_TERM_DIVQ = 4'd8;
	localparam logic [PC_W-1:0] A_TERM_FIX = 4'd9;
	localparam logic [PC_W-1:0] A_EXP_ACC = 4'd10;
	localparam logic [PC_W-1:0] A_IDX_MUL = 4'd11;
	localparam logic [PC_W-1:0] A_IDX_STORE = 4'd12;
	localparam logic [PC_W-1:0] A_EMIT = 4'd13;
	localparam logic [PC_W-1:0] A_RETURN = 4'd14;

	localparam logic [E_W-1:0] E_STD_LAST = 3'd2;
	localparam logic [E_W-1:0] E_SEA_LAST = 3'd5;
	localparam logic [E_W-1:0] E_DONE = 3'd6;
	localparam logic [1:0] POL_LAST = 2'(NPOL - 1);

	// sequencer
	logic [PC_W-1:0] pc_q;
	ucode_t uw;
	logic jump;

	// day accumulation
	logic [HOUR_W-1:0] hour_q;
	logic [SUM_W-1:0] sum_q [NPOL];
	logic [CNT_W-1:0] cnt_q [NPOL];
	logic [MONTH_W-1:0] month_q;
	logic [SAMPLE_W-1:0] samp [NPOL];
	logic samp_acc;
	logic day_done;

	// datapath
	logic [1:0] pol_q;
	logic [E_W-1:0] e_q;
	logic [4:0] n_q;
	logic [AVG_W-1:0] avg_q [NPOL];
	logic [ARGP_W-1:0] argp_q;
	logic [X_W-1:0] x_q;
	logic [TERM_W-1:0] term_q;
	logic [TP_W-1:0] tp_q;
	logic [Y_W-1:0] y_q;
	logic [QP_W-1:0] qp_q;
	logic [Y_W-1:0] q0_q;
	logic [REM_W-1:0] rem_q;
	logic [ESUM_W-1:0] esum_q;
	logic [S_W-1:0] s_q;
	logic [P_W-1:0] p_q;
	logic [IDX_W-1:0] std_idx_q;
	logic [IDX_W-1:0] sea_idx_q;

	logic div_busy;
	logic [SUM_W-1:0] div_quo;
	logic div_start;

	logic warm;
	logic sea_ok;
	logic [1:0] e_pol;
	logic [K_W-1:0] k_sel;
	logic [F_W-1:0] f_sel;
	logic [Y_W+4:0] qn;
	logic [Y_W-1:0] diff;
	logic [Y_W-1:0] term_nxt;
	logic [P_W:0] p_rnd;
	logic [P_W-RND_POS:0] p_int;
	logic [IDX_W-1:0] idx_val;
	logic [ARGP_W-ARG_SH-1:0] arg_full;

	// result register
	logic out_valid_q;
	logic out_busy;
	logic emit_fire;
	logic [AVG_W-1:0] o3_avg_q, no2_avg_q, pm25_avg_q;
	logic [IDX_W-1:0] std_out_q, sea_out_q;
	logic sea_ok_q;
	logic [RISK_W-1:0] std_risk_q, sea_risk_q;

	function automatic logic [RISK_W-1:0] risk_of(input logic [IDX_W-1:0] idx);
		if (idx < LIM_MODERATE) return RISK_LOW;
		if (idx < LIM_HIGH) return RISK_MODERATE;
		if (idx < LIM_VERY_HIGH) return RISK_HIGH;
		return RISK_VERY_HIGH;
	endfunction

	// control store
	always_comb begin
		case (pc_q)
			A_IDLE:      uw = '{OP_NOP, C_NO_DAY, A_IDLE};
			A_DIV_GO:    uw = '{OP_DIV_GO, C_NONE, A_IDLE};
			A_DIV_WAIT:  uw = '{OP_NOP, C_DIV_BUSY, A_DIV_WAIT};
			A_DIV_STORE: uw = '{OP_DIV_STORE, C_POL_MORE, A_DIV_GO};
			A_EXP_INIT:  uw = '{OP_EXP_INIT, C_NONE, A_IDLE};
			A_ARG_CLAMP: uw = '{OP_ARG_CLAMP, C_NONE, A_IDLE};
			A_TERM_MUL:  uw = '{OP_TERM_MUL, C_NONE, A_IDLE};
			A_RECIP_MUL: uw = '{OP_RECIP_MUL, C_NONE, A_IDLE};
			A_TERM_DIVQ: uw = '{OP_TERM_DIVQ, C_NONE, A_IDLE};
			A_TERM_FIX:  uw = '{OP_TERM_FIX, C_TERM_MORE, A_TERM_MUL};
			A_EXP_ACC:   uw = '{OP_EXP_ACC, C_GROUP_MORE, A_EXP_INIT};
			A_IDX_MUL:   uw = '{OP_IDX_MUL, C_NONE, A_IDLE};
			A_IDX_STORE: uw = '{OP_IDX_STORE, C_SEA_LEFT, A_EXP_INIT};
			A_EMIT:      uw = '{OP_EMIT, C_NONE, A_IDLE};
			A_RETURN:    uw = '{OP_NOP, C_ALWAYS, A_IDLE};
			default:     uw = '{OP_NOP, C_ALWAYS, A_IDLE};
		endcase
	end

	assign out_busy = out_valid_q && !result.ready;
	assign emit_fire = (uw.op == OP_EMIT) && !out_busy;

	always_comb begin
		case (uw.cond)
			C_NONE:       jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_NO_DAY:     jump = !day_done;
			C_DIV_BUSY:   jump = div_busy;
			C_POL_MORE:   jump = pol_q != POL_LAST;
			C_TERM_MORE:  jump = n_q != 5'(N_TERMS);
			C_GROUP_MORE: jump = (e_q != E_STD_LAST) && (e_q != E_SEA_LAST);
			C_SEA_LEFT:   jump = e_q != E_DONE;
			default:      jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_IDLE;
		end else if (uw.op == OP_EMIT && out_busy) begin
			pc_q <= pc_q;
		end else if (jump) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	// hourly intake
	assign sample.ready = pc_q == A_IDLE;
	assign samp_acc = sample.valid && sample.ready;
	assign day_done = samp_acc && (hour_q == HOUR_W'(HOURS_PER_DAY - 1));
	assign samp[0] = sample.o3_sample;
	assign samp[1] = sample.no2_sample;
	assign samp[2] = sample.pm25_sample;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q <= '0;
			for (int i = 0; i < NPOL; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (emit_fire) begin
			hour_q <= '0;
			for (int i = 0; i < NPOL; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (samp_acc) begin
			hour_q <= hour_q + 1'b1;
			for (int i = 0; i < NPOL; i++) begin
				// negative readings and the missing mark are skipped
				if (!samp[i][SAMPLE_W-1] && samp[i] != MISSING_MARK) begin
					sum_q[i] <= sum_q[i] + SUM_W'(samp[i][SAMPLE_W-2:0]);
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_q <= MONTH_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			month_q <= cfg.data;
		end
	end

	// daily averages
	assign div_start = uw.op == OP_DIV_GO;

	daqhi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[pol_q]),
		.divisor  (cnt_q[pol_q]),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// formula selection
	assign warm = month_q inside {[4'd4:4'd9]};
	assign sea_ok = month_q inside {[4'd1:4'd12]};

	always_comb begin
		case (e_q)
			3'd0: begin e_pol = 2'd0; k_sel = K_STD_O3; end
			3'd1: begin e_pol = 2'd1; k_sel = K_STD_NO2; end
			3'd2: begin e_pol = 2'd2; k_sel = K_STD_PM; end
			// cool formula has no ozone term: a zero coefficient gives exp - 1 = 0
			3'd3: begin e_pol = 2'd0; k_sel = warm ? K_WARM_O3 : '0; end
			3'd4: begin e_pol = 2'd1; k_sel = warm ? K_WARM_NO2 : K_COOL_NO2; end
			3'd5: begin e_pol = 2'd2; k_sel = warm ? K_WARM_PM : K_COOL_PM; end
			default: begin e_pol = 2'd0; k_sel = '0; end
		endcase
	end

	// e_q already points past the group when the scale factor is picked
	assign f_sel = (e_q == E_DONE) ? (warm ? F_WARM : F_COOL) : F_STD;

	assign arg_full = argp_q[ARGP_W-1:ARG_SH];
	assign qn = qp_q[QP_W-1:RCP_W] * n_q;
	assign diff = y_q - qn[Y_W-1:0];
	assign term_nxt = q0_q + Y_W'(rem_q >= REM_W'(n_q));

	// rounding of the q40 index product
	assign p_rnd = {1'b0, p_q} + ((P_W + 1)'(1) << (RND_POS - 1));
	assign p_int = p_rnd[P_W:RND_POS];

	always_comb begin
		if (p_q < (P_W'(1) << (RND_POS - 1))) begin
			idx_val = IDX_W'(1);
		end else if (p_int > (P_W - RND_POS + 1)'(255)) begin
			idx_val = IDX_W'(255);
		end else begin
			idx_val = p_int[IDX_W-1:0];
		end
	end

	// loop counters of the program
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q <= '0;
			e_q <= '0;
			n_q <= '0;
			s_q <= '0;
		end else begin
			case (uw.op)
				OP_DIV_STORE: pol_q <= pol_q + 1'b1;
				OP_EXP_INIT:  n_q <= 5'd1;
				OP_TERM_FIX:  n_q <= n_q + 1'b1;
				OP_EXP_ACC: begin
					e_q <= e_q + 1'b1;
					s_q <= s_q + S_W'(esum_q - ONE_Q24);
				end
				OP_IDX_STORE: s_q <= '0;
				OP_EMIT: begin
					if (emit_fire) begin
						pol_q <= '0;
						e_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_DIV_STORE: begin
				avg_q[pol_q] <= (cnt_q[pol_q] == '0) ? '0 : div_quo[AVG_W-1:0];
			end
			OP_EXP_INIT: begin
				argp_q <= avg_q[e_pol] * k_sel;
				term_q <= TERM_W'(ONE_Q24);
				esum_q <= ONE_Q24;
			end
			OP_ARG_CLAMP: begin
				x_q <= (arg_full > ARG_CAP) ? X_W'(ARG_CAP) : arg_full[X_W-1:0];
			end
			OP_TERM_MUL: tp_q <= term_q * x_q;
			OP_RECIP_MUL: begin
				y_q <= tp_q[TP_W-1:FRAC_W];
				qp_q <= tp_q[TP_W-1:FRAC_W] * recip(n_q);
			end
			OP_TERM_DIVQ: begin
				q0_q <= qp_q[QP_W-1:RCP_W];
				rem_q <= diff[REM_W-1:0];
			end
			OP_TERM_FIX: begin
				// quotient estimate is low by at most one
				term_q <= term_nxt[TERM_W-1:0];
				esum_q <= esum_q + ESUM_W'(term_nxt);
			end
			OP_IDX_MUL: p_q <= s_q * f_sel;
			OP_IDX_STORE: begin
				if (e_q == E_DONE) begin
					sea_idx_q <= idx_val;
				end else begin
					std_idx_q <= idx_val;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			o3_avg_q <= avg_q[0];
			no2_avg_q <= avg_q[1];
			pm25_avg_q <= avg_q[2];
			std_out_q <= std_idx_q;
			std_risk_q <= risk_of(std_idx_q);
			sea_ok_q <= sea_ok;
			sea_out_q <= sea_ok ? sea_idx_q : '0;
			sea_risk_q <= sea_ok ? risk_of(sea_idx_q) : RISK_LOW;
		end
	end

	assign result.valid = out_valid_q;
	assign result.o3_average = o3_avg_q;
	assign result.no2_average = no2_avg_q;
	assign result.pm25_average = pm25_avg_q;
	assign result.standard_index = std_out_q;
	assign result.seasonal_index = sea_out_q;
	assign result.seasonal_valid = sea_ok_q;
	assign result.standard_risk = std_risk_q;
	assign result.seasonal_risk = sea_risk_q;

endmodule

/* bench/daily_aqhi_engine_top_tb.sv */
// self-checking testbench of the daily aqhi engine with its own index predictor
`timescale 1ns / 100ps

module daily_aqhi_engine_top_tb;
	import daqhi_pkg::*;

	localparam int unsigned QUIET_LIMIT = 20000;
	localparam int unsigned HOLD_CYCLES = 1500;
	localparam int unsigned DRAIN_CYCLES = 600;

	typedef struct {
		logic signed [SAMPLE_W-1:0] o3;
		logic signed [SAMPLE_W-1:0] no2;
		logic signed [SAMPLE_W-1:0] pm25;
	} reading_t;

	typedef struct {
		logic [AVG_W-1:0] o3_avg;
		logic [AVG_W-1:0] no2_avg;
		logic [AVG_W-1:0] pm25_avg;
		logic [IDX_W-1:0] std_idx;
		logic [IDX_W-1:0] sea_idx;
		logic sea_ok;
		logic [RISK_W-1:0] std_risk;
		logic [RISK_W-1:0] sea_risk;
	} day_report_t;

	logic clk = 1'b0;
	logic arst_n;

	daqhi_sample_if sample_ch();
	daqhi_result_if result_ch();
	daqhi_cfg_if cfg_ch();

	daily_aqhi_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// predictor state
	logic [HOUR_W-1:0] hours_seen;
	logic [SUM_W-1:0] day_sum [NPOL];
	logic [CNT_W-1:0] day_cnt [NPOL];
	logic [MONTH_W-1:0] month_reg;

	reading_t hourly_queue[$];
	day_report_t daily_reports[$];

	bit steady = 1'b0;
	int unsigned mismatches = 0;
	int unsigned days_checked = 0;
	int unsigned quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] coef_q40(input int unsigned micro);
		return (64'(micro) * (64'd1 << 40) + 64'd5000000) / 64'd10000000;
	endfunction

	// 1000 / divisor in Q16, divisor given in hundredths
	function automatic logic [63:0] scale_q16(input int unsigned d);
		return (64'd6553600000 + 64'(d / 2)) / 64'(d);
	endfunction

	// exp(avg * k) - 1 in Q24 by a truncated series, argument capped at 2.0
	function automatic logic [63:0] exp_rise(input logic [63:0] avg, input logic [63:0] coef);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] total;
		x = (avg * coef) >> 16;
		if (x > (64'd2 << 24))
			x = 64'd2 << 24;
		term = 64'd1 << 24;
		total = term;
		for (int n = 1; n <= 20; n++) begin
			term = ((term * x) >> 24) / 64'(n);
			total = total + term;
		end
		return total - (64'd1 << 24);
	endfunction

	function automatic logic [IDX_W-1:0] index_of(input logic [63:0] s, input logic [63:0] f);
		logic [63:0] p;
		logic [63:0] r;
		p = s * f;
		if (p < (64'd1 << 39))
			return IDX_W'(1);
		r = (p + (64'd1 << 39)) >> 40;
		return (r > 64'd255) ? IDX_W'(255) : IDX_W'(r);
	endfunction

	function automatic logic [RISK_W-1:0] risk_class(input logic [IDX_W-1:0] idx);
		if (idx < LIM_MODERATE)
			return RISK_LOW;
		if (idx < LIM_HIGH)
			return RISK_MODERATE;
		if (idx < LIM_VERY_HIGH)
			return RISK_HIGH;
		return RISK_VERY_HIGH;
	endfunction

	// fold one hourly word into the day; a closing word yields an expected report
	function automatic void absorb_reading(input logic signed [SAMPLE_W-1:0] o3,
		input logic signed [SAMPLE_W-1:0] no2, input logic signed [SAMPLE_W-1:0] pm25);
		logic [SAMPLE_W-1:0] raw [NPOL];
		logic [63:0] avg [NPOL];
		logic [63:0] s_std;
		logic [63:0] s_sea;
		day_report_t rep;
		raw[0] = o3;
		raw[1] = no2;
		raw[2] = pm25;
		for (int i = 0; i < NPOL; i++) begin
			if (!raw[i][SAMPLE_W-1] && raw[i] != MISSING_MARK) begin
				day_sum[i] = day_sum[i] + SUM_W'(raw[i]);
				day_cnt[i] = day_cnt[i] + 1'b1;
			end
		end
		hours_seen = hours_seen + 1'b1;
		if (hours_seen != HOUR_W'(HOURS_PER_DAY))
			return;
		for (int i = 0; i < NPOL; i++)
			avg[i] = (day_cnt[i] != 0) ? 64'(AVG_W'(day_sum[i] / day_cnt[i])) : 64'd0;
		s_std = exp_rise(avg[0], coef_q40(537)) + exp_rise(avg[1], coef_q40(871))
			+ exp_rise(avg[2], coef_q40(487));
		rep.o3_avg = AVG_W'(avg[0]);
		rep.no2_avg = AVG_W'(avg[1]);
		rep.pm25_avg = AVG_W'(avg[2]);
		rep.std_idx = index_of(s_std, scale_q16(1040));
		rep.std_risk = risk_class(rep.std_idx);
		rep.sea_ok = (month_reg >= 1 && month_reg <= 12);
		rep.sea_idx = '0;
		if (month_reg >= 4 && month_reg <= 9) begin
			s_sea = exp_rise(avg[0], coef_q40(1040)) + exp_rise(avg[1], coef_q40(1010))
				+ exp_rise(avg[2], coef_q40(621));
			rep.sea_idx = index_of(s_sea, scale_q16(1280));
		end else if (rep.sea_ok) begin
			s_sea = exp_rise(avg[1], coef_q40(457)) + exp_rise(avg[2], coef_q40(462));
			rep.sea_idx = index_of(s_sea, scale_q16(643));
		end
		rep.sea_risk = rep.sea_ok ? risk_class(rep.sea_idx) : RISK_LOW;
		daily_reports.push_back(rep);
		hours_seen = '0;
		for (int i = 0; i < NPOL; i++) begin
			day_sum[i] = '0;
			day_cnt[i] = '0;
		end
	endfunction

	function automatic void compare_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// level zero means the pollutant is missing all day
	function automatic int unsigned pick_level();
		case ($urandom_range(9))
			0: return 0;
			1, 2: return 300;
			3, 4: return 800;
			5: return 2000;
			6: return 5000;
			7: return 20000;
			8: return 524287;
			default: return 60;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_reading(input int unsigned level);
		int unsigned roll;
		roll = $urandom_range(99);
		if (level == 0)
			return roll[0] ? {1'b1, 19'($urandom)} : MISSING_MARK;
		if (roll < 6)
			return {1'b1, 19'($urandom)};
		if (roll < 10)
			return MISSING_MARK;
		if (roll < 12)
			return roll[0] ? SAMPLE_W'(MISSING_MARK + 1) : SAMPLE_W'(MISSING_MARK - 1);
		if (roll < 15)
			return SAMPLE_W'($urandom);
		return SAMPLE_W'($urandom_range(level, 0));
	endfunction

	task automatic queue_days(input int days);
		reading_t r;
		int unsigned lv [NPOL];
		for (int d = 0; d < days; d++) begin
			for (int i = 0; i < NPOL; i++)
				lv[i] = pick_level();
			for (int h = 0; h < HOURS_PER_DAY; h++) begin
				r.o3 = pick_reading(lv[0]);
				r.no2 = pick_reading(lv[1]);
				r.pm25 = pick_reading(lv[2]);
				hourly_queue.push_back(r);
			end
		end
	endtask

	// wait until every queued word is taken and every report has come back
	task automatic settle();
		do
			@(negedge clk);
		while (hourly_queue.size() != 0 || sample_ch.valid || daily_reports.size() != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_month(input logic [MONTH_W-1:0] m);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= m;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		month_reg = m;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [MONTH_W-1:0] m, input int days, input bit calm);
		settle();
		write_month(m);
		steady = calm;
		queue_days(days);
	endtask

	initial begin : stimulus
		reading_t r;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.o3_sample = '0;
		sample_ch.no2_sample = '0;
		sample_ch.pm25_sample = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		hours_seen = '0;
		for (int i = 0; i < NPOL; i++) begin
			day_sum[i] = '0;
			day_cnt[i] = '0;
		end
		month_reg = MONTH_W'(1);
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// ozone missing all day, nitrogen dioxide far past the exponent cap,
		// values around the missing mark, small particulates
		for (int h = 0; h < HOURS_PER_DAY; h++) begin
			case (h % 3)
				0: r.o3 = -20'sd524288;
				1: r.o3 = MISSING_MARK;
				default: r.o3 = -20'sd1;
			endcase
			case (h % 4)
				0: r.no2 = 20'sd524287;
				1: r.no2 = SAMPLE_W'(MISSING_MARK - 1);
				2: r.no2 = SAMPLE_W'(MISSING_MARK + 1);
				default: r.no2 = '0;
			endcase
			r.pm25 = (h % 2) ? SAMPLE_W'(0) : SAMPLE_W'(h);
			hourly_queue.push_back(r);
		end

		run_phase(4'd4, 8, 1'b0);
		run_phase(4'd0, 3, 1'b0);
		run_phase(4'd9, 5, 1'b1);
		run_phase(4'd12, 5, 1'b0);
		run_phase(4'd13, 3, 1'b0);
		run_phase(4'd3, 5, 1'b0);
		run_phase(4'd10, 5, 1'b0);
		run_phase(4'd15, 3, 1'b0);
		run_phase(4'd7, 5, 1'b0);
		run_phase(4'd1, 5, 1'b0);
		repeat (3)
			run_phase(MONTH_W'($urandom_range(15)), 2, 1'b0);
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin : drive
		reading_t nxt;
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				absorb_reading(sample_ch.o3_sample, sample_ch.no2_sample,
					sample_ch.pm25_sample);
			if (!sample_ch.valid || sample_ch.ready) begin
				if (hourly_queue.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
					nxt = hourly_queue.pop_front();
					sample_ch.valid <= 1'b1;
					sample_ch.o3_sample <= nxt.o3;
					sample_ch.no2_sample <= nxt.no2;
					sample_ch.pm25_sample <= nxt.pm25;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : observe
		day_report_t want;
		logic take;
		int unsigned hold_left;
		bit hold_done;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (daily_reports.size() == 0) begin
					$display("%0t: result word expected none, got o3_average %0d index %0d",
						$time, result_ch.o3_average, result_ch.standard_index);
					mismatches++;
				end else begin
					want = daily_reports.pop_front();
					compare_field("o3_average", want.o3_avg, result_ch.o3_average);
					compare_field("no2_average", want.no2_avg, result_ch.no2_average);
					compare_field("pm25_average", want.pm25_avg, result_ch.pm25_average);
					compare_field("standard_index", want.std_idx, result_ch.standard_index);
					compare_field("seasonal_index", want.sea_idx, result_ch.seasonal_index);
					compare_field("seasonal_valid", want.sea_ok, result_ch.seasonal_valid);
					compare_field("standard_risk", want.std_risk, result_ch.standard_risk);
					compare_field("seasonal_risk", want.sea_risk, result_ch.seasonal_risk);
					days_checked++;
				end
			end
			// one long hold-off while words keep coming, so the input backs up
			if (hold_left != 0) begin
				hold_left--;
				take = 1'b0;
			end else if (days_checked == 3 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				take = 1'b0;
			end else begin
				take = steady || ($urandom_range(99) >= 36);
			end
			result_ch.ready <= take;
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (sample_ch.valid && sample_ch.ready)
			|| (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

/* sim.f */
rtl/daqhi_pkg.sv
rtl/daqhi_if.sv
rtl/daqhi_div.sv
rtl/daily_aqhi_engine_top.sv
bench/daily_aqhi_engine_top_tb.sv
